### rtl/swarq_pkg.sv
// ============================================================================
// swarq_pkg: shared types and constants for the sliding-window ARQ sender
// Holds the input and result beat structs, action and reply codes, and the
// frame descriptor kept in the window and backlog stores.
// ============================================================================
package swarq_pkg;

    localparam int WINDOW_DEPTH_DEF  = 8;
    localparam int BACKLOG_DEPTH_DEF = 16;

    localparam logic [1:0] ACT_SEND    = 2'd0;
    localparam logic [1:0] ACT_REPLY   = 2'd1;
    localparam logic [1:0] ACT_TIMEOUT = 2'd2;

    localparam logic [1:0] KIND_ACK = 2'd1;
    localparam logic [1:0] KIND_NAK = 2'd2;

    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] frame_seq;
        logic [7:0]  frame_len;
        logic [7:0]  frame_tag;
        logic [1:0]  reply_kind;
        logic [31:0] reply_ack;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]  tx_tag;
        logic [31:0] tx_seq;
        logic [7:0]  tx_len;
        logic        is_resend;
        logic        overflow;
        logic        last;
    } t_out_beat;

    typedef struct packed {
        logic [31:0] seq;
        logic [7:0]  len;
        logic [7:0]  tag;
    } t_desc;

endpackage

### rtl/swarq_ram.sv
// ============================================================================
// swarq_ram: generic single-port-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module swarq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/swarq_front.sv
// ============================================================================
// swarq_front: input queue stage
// Registers accepted input beats in a two-entry queue so the engine behind it
// can stall independently of the producer.
// ============================================================================
module swarq_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  swarq_pkg::t_in_beat  i_beat,
    output logic                 o_valid,
    input  logic                 i_take,
    output swarq_pkg::t_in_beat  o_beat
);
    import swarq_pkg::*;

    t_in_beat   r_q [2];
    logic       r_rd;
    logic       r_wr;
    logic [1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_beat  = r_q[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr] <= i_beat;
        end
    end
endmodule

### rtl/swarq_engine.sv
// ============================================================================
// swarq_engine: window and backlog sequencer
// Carries out one event at a time: appends sends to the backlog, scans the
// window for ack, nak and timeout matches one entry per cycle, and emits
// transmits into a held result register ahead of a two-deep output queue.
// ============================================================================
module swarq_engine #(
    parameter int WINDOW_DEPTH  = swarq_pkg::WINDOW_DEPTH_DEF,
    parameter int BACKLOG_DEPTH = swarq_pkg::BACKLOG_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_mode,
    input  logic [3:0]           i_limit,
    input  logic                 i_valid,
    output logic                 o_take,
    input  swarq_pkg::t_in_beat  i_beat,
    output logic                 o_empty,
    input  logic                 i_pop,
    output swarq_pkg::t_out_beat o_beat
);
    import swarq_pkg::*;

    localparam int WW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int BW = $clog2(BACKLOG_DEPTH);
    localparam int WC = $clog2(WINDOW_DEPTH + 1);
    localparam int BC = $clog2(BACKLOG_DEPTH + 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_GBN   = 6'b000100,
        ST_RFREQ = 6'b001000,
        ST_RFOUT = 6'b010000,
        ST_EMIT  = 6'b100000
    } t_state;

    t_state         r_state, n_state;
    t_in_beat       r_ev;
    logic [WW-1:0]  r_whead;
    logic [WC-1:0]  r_wcnt;
    logic [BW-1:0]  r_bhead;
    logic [BC-1:0]  r_bcnt;
    logic [WC-1:0]  r_idx;
    logic           r_pend;     // a result is held back until we know if it is last
    t_out_beat      r_pbeat;

    // Window store is small and read at one scan address: flip-flops.
    t_desc          r_win [WINDOW_DEPTH];

    // Output two-deep queue.
    t_out_beat      r_oq [2];
    logic           r_ord, r_owr;
    logic [1:0]     r_ocnt;

    logic [WC-1:0]  lim;
    logic [WW-1:0]  widx;
    t_desc          wdesc;
    logic           room;
    logic           emit;
    t_out_beat      ebeat;
    logic           flush;
    logic           out_pop;
    logic           push_q;
    logic           b_we;
    logic [BW-1:0]  b_waddr;
    logic [47:0]    b_rdata;
    logic [31:0]    match_key;
    logic           release_mode;

    // Ring pointer wrap: the sum is always below twice the depth.
    function automatic logic [WW-1:0] wrap_w(int unsigned v);
        return (v >= WINDOW_DEPTH) ? WW'(v - WINDOW_DEPTH) : WW'(v);
    endfunction

    function automatic logic [BW-1:0] wrap_b(int unsigned v);
        return (v >= BACKLOG_DEPTH) ? BW'(v - BACKLOG_DEPTH) : BW'(v);
    endfunction

    always_comb begin
        if (i_limit == 4'd0) begin
            lim = WC'(1);
        end else if ({28'd0, i_limit} > WINDOW_DEPTH) begin
            lim = WC'(WINDOW_DEPTH);
        end else begin
            lim = WC'(i_limit);
        end
    end

    assign widx  = wrap_w(32'(r_whead) + 32'(r_idx));
    assign wdesc = r_win[widx];
    // Room for two beats so a held result and a new one can both land.
    assign room  = (r_ocnt == 2'd0);
    assign out_pop = i_pop && !o_empty;
    assign o_empty = (r_ocnt == 2'd0);
    assign o_beat  = r_oq[r_ord];
    assign o_take  = (r_state == ST_IDLE) && !r_pend && room && i_valid;
    assign b_waddr = wrap_b(32'(r_bhead) + 32'(r_bcnt));
    assign b_we    = o_take && (i_beat.action == ACT_SEND) && (r_bcnt != BC'(BACKLOG_DEPTH));
    assign match_key    = (r_ev.action == ACT_TIMEOUT) ? r_ev.frame_seq : r_ev.reply_ack;
    assign release_mode = (r_ev.action == ACT_REPLY) &&
                          ((!i_mode) || (r_ev.reply_kind == KIND_ACK));
    // Held result goes out when a newer one arrives or at event end.
    assign push_q  = r_pend ? (emit || flush) : (emit && flush);

    swarq_ram #(.WIDTH(48), .DEPTH(BACKLOG_DEPTH)) u_backlog (
        .i_clk  (i_clk),
        .i_we   (b_we),
        .i_waddr(b_waddr),
        .i_wdata({i_beat.frame_seq, i_beat.frame_len, i_beat.frame_tag}),
        .i_raddr(r_bhead),
        .o_rdata(b_rdata)
    );

    // Sequencer: emit produces a beat; flush marks the held beat, or a beat emitted with it, last.
    always_comb begin
        n_state = r_state;
        emit    = 1'b0;
        flush   = 1'b0;
        ebeat   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (o_take) begin
                    unique case (i_beat.action)
                        ACT_SEND: begin
                            if (r_bcnt == BC'(BACKLOG_DEPTH)) begin
                                n_state = ST_EMIT;
                            end else if (r_wcnt < lim) begin
                                n_state = ST_RFREQ;
                            end
                        end
                        ACT_REPLY: begin
                            if (!i_mode || i_beat.reply_kind == KIND_ACK ||
                                i_beat.reply_kind == KIND_NAK) begin
                                n_state = ST_SCAN;
                            end else begin
                                n_state = ST_RFREQ;
                            end
                        end
                        ACT_TIMEOUT: begin
                            n_state = i_mode ? ST_SCAN : ST_GBN;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_EMIT: begin
                // Overflow result.
                emit = 1'b1;
                ebeat.overflow = 1'b1;
                flush = 1'b1;
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                if (r_idx >= r_wcnt) begin
                    if (r_ev.action == ACT_REPLY) begin
                        n_state = ST_RFREQ;
                    end else begin
                        flush = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else if (wdesc.seq == match_key) begin
                    if (!release_mode) begin
                        if (room) begin
                            emit = 1'b1;
                            ebeat.tx_tag = wdesc.tag;
                            ebeat.tx_seq = wdesc.seq;
                            ebeat.tx_len = wdesc.len;
                            ebeat.is_resend = 1'b1;
                            if (r_ev.action == ACT_REPLY) begin
                                n_state = ST_RFREQ;
                            end else begin
                                flush = 1'b1;
                                n_state = ST_IDLE;
                            end
                        end
                    end else begin
                        n_state = ST_RFREQ;
                    end
                end
            end
            ST_GBN: begin
                if (r_idx >= r_wcnt) begin
                    flush = 1'b1;
                    n_state = ST_IDLE;
                end else if (room) begin
                    emit = 1'b1;
                    ebeat.tx_tag = wdesc.tag;
                    ebeat.tx_seq = wdesc.seq;
                    ebeat.tx_len = wdesc.len;
                    ebeat.is_resend = 1'b1;
                end
            end
            ST_RFREQ: begin
                // Backlog RAM read address is r_bhead; data valid next cycle.
                if (r_wcnt < lim && r_bcnt != '0) begin
                    n_state = ST_RFOUT;
                end else begin
                    flush = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_RFOUT: begin
                if (room) begin
                    emit = 1'b1;
                    ebeat.tx_seq = b_rdata[47:16];
                    ebeat.tx_len = b_rdata[15:8];
                    ebeat.tx_tag = b_rdata[7:0];
                    n_state = (r_ev.action == ACT_SEND) ? ST_IDLE : ST_RFREQ;
                    flush = (r_ev.action == ACT_SEND);
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_whead <= '0;
            r_wcnt  <= '0;
            r_bhead <= '0;
            r_bcnt  <= '0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_ord   <= 1'b0;
            r_owr   <= 1'b0;
            r_ocnt  <= 2'd0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE) begin
                r_idx <= '0;
                if (b_we) begin
                    r_bcnt <= r_bcnt + BC'(1);
                end
            end
            if (r_state == ST_SCAN) begin
                if (r_idx < r_wcnt && wdesc.seq == match_key) begin
                    if (release_mode) begin
                        r_whead <= wrap_w(32'(r_whead) + 32'(r_idx) + 32'd1);
                        r_wcnt  <= r_wcnt - r_idx - WC'(1);
                    end
                end else if (r_idx >= r_wcnt) begin
                    if (release_mode) begin
                        r_whead <= '0;
                        r_wcnt  <= '0;
                    end
                end else begin
                    r_idx <= r_idx + WC'(1);
                end
            end
            if (r_state == ST_GBN && emit) begin
                r_idx <= r_idx + WC'(1);
            end
            if (r_state == ST_RFOUT && emit) begin
                r_bhead <= wrap_b(32'(r_bhead) + 32'd1);
                r_bcnt  <= r_bcnt - BC'(1);
                r_wcnt  <= r_wcnt + WC'(1);
            end
            if (emit) begin
                r_pend <= ~flush;
            end else if (flush) begin
                r_pend <= 1'b0;
            end
            if (push_q) begin
                r_owr <= ~r_owr;
            end
            if (out_pop) begin
                r_ord <= ~r_ord;
            end
            r_ocnt <= r_ocnt + {1'b0, push_q} - {1'b0, out_pop};
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_ev <= i_beat;
        end
        if (emit) begin
            r_pbeat <= ebeat;
        end
        if (r_state == ST_RFOUT && emit) begin
            r_win[wrap_w(32'(r_whead) + 32'(r_wcnt))] <= b_rdata;
        end
        // Emit with a held beat pushes the held one. Emit and flush together
        // only happen on the first result of an event, which goes in as last.
        if (emit && r_pend) begin
            r_oq[r_owr] <= '{tx_tag: r_pbeat.tx_tag, tx_seq: r_pbeat.tx_seq,
                             tx_len: r_pbeat.tx_len, is_resend: r_pbeat.is_resend,
                             overflow: r_pbeat.overflow, last: 1'b0};
        end else if (emit && flush) begin
            r_oq[r_owr] <= '{tx_tag: ebeat.tx_tag, tx_seq: ebeat.tx_seq,
                             tx_len: ebeat.tx_len, is_resend: ebeat.is_resend,
                             overflow: ebeat.overflow, last: 1'b1};
        end else if (flush && r_pend) begin
            r_oq[r_owr] <= '{tx_tag: r_pbeat.tx_tag, tx_seq: r_pbeat.tx_seq,
                             tx_len: r_pbeat.tx_len, is_resend: r_pbeat.is_resend,
                             overflow: r_pbeat.overflow, last: 1'b1};
        end
    end
endmodule

### rtl/sliding_window_arq_sender.sv
// ============================================================================
// sliding_window_arq_sender: go-back-N / selective-repeat ARQ sender
// Queue-style input and result ports around a window/backlog sequencer.
// ============================================================================
// Events are handled one at a time, and the next one is taken only after
// every result of the previous one has left the output queue. A send into a
// full window is only appended to the backlog, an overflow yields one
// overflow result and a send that transmits reads the backlog head out. A
// reply or timeout scans the window entry by entry, then a reply refills
// the window from the backlog RAM through a read-request and an output
// state per frame. A result waits while the output queue holds a beat, so
// receiver stalls hold an event up. Each result is held one step so the
// final one can be marked last; results then drain through a small output
// queue.
module sliding_window_arq_sender #(
    parameter int WINDOW_DEPTH  = swarq_pkg::WINDOW_DEPTH_DEF,
    parameter int BACKLOG_DEPTH = swarq_pkg::BACKLOG_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  swarq_pkg::t_in_beat  i_in,
    output logic                 empty,
    input  logic                 pop,
    output swarq_pkg::t_out_beat o_out,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [3:0]           i_cfg_data
);
    import swarq_pkg::*;

    logic     r_mode;
    logic [3:0] r_limit;
    logic     f_valid;
    logic     f_take;
    t_in_beat f_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_limit <= 4'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:  r_mode  <= i_cfg_data[0];
                CFG_LIMIT: r_limit <= i_cfg_data;
                default:   r_mode  <= r_mode;
            endcase
        end
    end

    swarq_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_full (full),
        .i_beat (i_in),
        .o_valid(f_valid),
        .i_take (f_take),
        .o_beat (f_beat)
    );

    swarq_engine #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .BACKLOG_DEPTH(BACKLOG_DEPTH)
    ) u_engine (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_mode (r_mode),
        .i_limit(r_limit),
        .i_valid(f_valid),
        .o_take (f_take),
        .i_beat (f_beat),
        .o_empty(empty),
        .i_pop  (pop),
        .o_beat (o_out)
    );
endmodule

### rtl/swarq_checker.sv
// ============================================================================
// swarq_checker: port-level checks for the ARQ sender
// Watches the result port for consistent overflow results and for results held stable while waiting.
// ============================================================================
module swarq_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_empty,
    input logic                 i_pop,
    input swarq_pkg::t_out_beat i_out
);
    a_ovf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && i_out.overflow) |-> i_out.last)
        else $error("overflow result not last");
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && i_out.overflow) |-> (i_out.tx_seq == 32'd0 && !i_out.is_resend))
        else $error("overflow result carries a descriptor");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && !i_pop) |=> (!i_empty && $stable(i_out)))
        else $error("result changed while waiting");
endmodule

bind sliding_window_arq_sender swarq_checker u_chk (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_empty(empty),
    .i_pop  (pop),
    .i_out  (o_out)
);
